FILE: rtl/bwgm_pkg.sv
package bwgm_pkg;

    // nibble width of one symbol and symbols held in one input word
    localparam int unsigned NIB_W      = 4;
    localparam int unsigned WORD_NIBS  = 16;
    localparam int unsigned WORD_W     = NIB_W * WORD_NIBS;
    localparam int unsigned CFG_IDX_W  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STAR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANY_ONE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END     = 2'd2;

    // register reset values
    localparam logic [NIB_W-1:0] STAR_RST    = 4'd10;
    localparam logic [NIB_W-1:0] ANY_ONE_RST = 4'd11;
    localparam logic [NIB_W-1:0] END_RST     = 4'd15;

    // kind of the pattern symbol being applied
    typedef enum logic [1:0] {
        PK_STAR,
        PK_ONE,
        PK_LIT
    } t_pkind;

    // sequencer state
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // control broadcast to every cell
    typedef struct packed {
        logic             load;
        logic             step;
        t_pkind           kind;
        logic [NIB_W-1:0] pat;
    } t_cell_ctrl;

endpackage

FILE: rtl/bwgm_cell.sv
module bwgm_cell
    import bwgm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctrl       i_ctrl,
    input  logic             i_init,
    input  logic [NIB_W-1:0] i_sym,
    input  logic             i_live,
    input  logic             i_left,
    input  logic             i_star_or,
    output logic             o_match,
    output logic             o_live
);

    logic             r_state;
    logic             n_state;
    logic             r_live;
    logic [NIB_W-1:0] r_sym;

    // one column of the match table: apply the current pattern symbol
    always_comb begin
        n_state = r_state;
        if (i_ctrl.load) begin
            n_state = i_init;
        end else if (i_ctrl.step) begin
            unique case (i_ctrl.kind)
                PK_STAR: n_state = r_state | i_star_or;
                PK_ONE:  n_state = i_left;
                PK_LIT:  n_state = i_left & (r_sym == i_ctrl.pat);
                default: n_state = 1'b0;
            endcase
        end
    end

    // match bit and length flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= 1'b0;
            r_live  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_ctrl.load) begin
                r_live <= i_live;
            end
        end
    end

    // subject symbol held by this cell
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_sym <= i_sym;
        end
    end

    assign o_match = r_state;
    assign o_live  = r_live;

endmodule

FILE: rtl/bcd_wildcard_glob_match_top.sv
// Glob match of a nibble pattern against a nibble subject.
//
// Request channel: drive i_subject and i_pattern with start high; the request
// is taken at a clock edge where start is high and busy is low. busy stays
// high while the request is worked on.
// Result channel: o_valid pulses for one cycle with o_matched; the receiver
// cannot stall, so the result must be taken in that cycle.
// Config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data
// write star code (0), any-one code (1) and end code (2); write only while idle.
//
// A row of LIMIT+1 cells, one per subject prefix length, holds the match
// column; one pattern symbol is applied to the whole row per cycle.
// The row steps through the lp pattern symbols, lp being the pattern length
// (at most LIMIT = min(SYMBOLS,16)), then the result is registered into
// o_valid; a new request is taken at the earliest at the edge that ends
// the o_valid cycle, so a new request is not taken before the last result
// has been shown.
// Reset (synchronous, active low) returns to idle and restores the codes to
// star 10, any-one 11, end 15.
module bcd_wildcard_glob_match_top
    import bwgm_pkg::*;
#(
    parameter int unsigned SYMBOLS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [WORD_W-1:0]    i_subject,
    input  logic [WORD_W-1:0]    i_pattern,
    output logic                 o_valid,
    output logic                 o_matched,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [NIB_W-1:0]     i_cfg_data
);

    localparam int unsigned LIMIT = (SYMBOLS < WORD_NIBS) ? SYMBOLS : WORD_NIBS;
    localparam int unsigned PW    = NIB_W * LIMIT;
    localparam int unsigned CW    = $clog2(LIMIT + 1);

    logic [NIB_W-1:0] r_star;
    logic [NIB_W-1:0] r_any;
    logic [NIB_W-1:0] r_end;

    t_state           r_st;
    t_state           n_st;
    logic [PW-1:0]    r_pat;
    logic [PW-1:0]    n_pat;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    n_cnt;
    logic             r_valid;
    logic             n_valid;
    logic             r_matched;
    logic             n_matched;

    t_cell_ctrl       ctrl;
    t_pkind           cur_kind;
    logic [NIB_W-1:0] cur_pat;
    logic [LIMIT:0]   cell_match;
    logic [LIMIT:0]   cell_live;
    logic [LIMIT:0]   load_live;
    logic [LIMIT:0]   star_or;
    logic [LIMIT:0]   left_in;
    logic [LIMIT-1:0] sub_neq;
    logic             final_match;

    // config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_star <= STAR_RST;
            r_any  <= ANY_ONE_RST;
            r_end  <= END_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_STAR) begin
                r_star <= i_cfg_data;
            end
            if (i_cfg_index == CFG_ANY_ONE) begin
                r_any <= i_cfg_data;
            end
            if (i_cfg_index == CFG_END) begin
                r_end <= i_cfg_data;
            end
        end
    end

    // subject length flags: cell j lies within the subject when no end code precedes it
    genvar g;
    generate
        for (g = 0; g < LIMIT; g++) begin : g_neq
            assign sub_neq[g] = (i_subject[WORD_W-1-NIB_W*g -: NIB_W] != r_end);
        end
    endgenerate

    assign load_live[0] = 1'b1;
    generate
        for (g = 1; g <= LIMIT; g++) begin : g_live
            assign load_live[g] = &sub_neq[g-1:0];
        end
    endgenerate

    // star spans: or of all shorter prefixes
    assign star_or[0] = 1'b0;
    assign left_in[0] = 1'b0;
    generate
        for (g = 1; g <= LIMIT; g++) begin : g_star
            assign star_or[g] = |cell_match[g-1:0];
            assign left_in[g] = cell_match[g-1];
        end
    endgenerate

    // current pattern symbol and its kind: star first, then any-one, else literal
    assign cur_pat = r_pat[PW-1 -: NIB_W];

    always_comb begin
        if (cur_pat == r_star) begin
            cur_kind = PK_STAR;
        end else if (cur_pat == r_any) begin
            cur_kind = PK_ONE;
        end else begin
            cur_kind = PK_LIT;
        end
    end

    // result: match bit of the cell at the subject length
    always_comb begin
        final_match = 1'b0;
        for (int k = 0; k < LIMIT; k++) begin
            final_match = final_match | (cell_match[k] & cell_live[k] & ~cell_live[k+1]);
        end
        final_match = final_match | (cell_match[LIMIT] & cell_live[LIMIT]);
    end

    // sequencer
    always_comb begin
        n_st      = r_st;
        n_pat     = r_pat;
        n_cnt     = r_cnt;
        n_valid   = 1'b0;
        n_matched = r_matched;
        ctrl.pat  = cur_pat;
        ctrl.kind = cur_kind;
        ctrl.load = 1'b0;
        ctrl.step = 1'b0;
        unique case (r_st)
            ST_IDLE: begin
                if (start) begin
                    ctrl.load = 1'b1;
                    n_pat     = i_pattern[WORD_W-1 -: PW];
                    n_cnt     = '0;
                    n_st      = ST_RUN;
                end
            end
            ST_RUN: begin
                if ((r_cnt == CW'(LIMIT)) || (cur_pat == r_end)) begin
                    n_valid   = 1'b1;
                    n_matched = final_match;
                    n_st      = ST_IDLE;
                end else begin
                    ctrl.step = 1'b1;
                    n_pat     = {r_pat[PW-NIB_W-1:0], {NIB_W{1'b0}}};
                    n_cnt     = r_cnt + 1'b1;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= ST_IDLE;
            r_cnt     <= '0;
            r_valid   <= 1'b0;
            r_matched <= 1'b0;
        end else begin
            r_st      <= n_st;
            r_cnt     <= n_cnt;
            r_valid   <= n_valid;
            r_matched <= n_matched;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pat <= n_pat;
    end

    assign busy      = (r_st != ST_IDLE);
    assign o_valid   = r_valid;
    assign o_matched = r_matched;

    // row of cells, cell j tracks a match against the first j subject symbols
    generate
        for (g = 0; g <= LIMIT; g++) begin : g_cell
            logic [NIB_W-1:0] cell_sym;
            if (g == 0) begin : g_first
                assign cell_sym = '0;
            end else begin : g_rest
                assign cell_sym = i_subject[WORD_W-1-NIB_W*(g-1) -: NIB_W];
            end
            bwgm_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctrl    (ctrl),
                .i_init    (g == 0),
                .i_sym     (cell_sym),
                .i_live    (load_live[g]),
                .i_left    (left_in[g]),
                .i_star_or (star_or[g]),
                .o_match   (cell_match[g]),
                .o_live    (cell_live[g])
            );
        end
    endgenerate

    // checks
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe longer than one cycle");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !busy)
        else $error("result shown while still busy");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_cnt <= CW'(LIMIT)))
        else $error("pattern counter past limit");

    a_empty_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && (cell_match == '0)) |=> (busy || !o_matched))
        else $error("match reported with empty match column");

endmodule
